>>> rtl/lcd_segment_delta_serializer_macros.svh
// Assertion macros shared by the serializer RTL.
// Include with the bare file name; needs no package.
`ifndef LCD_SEGMENT_DELTA_SERIALIZER_MACROS_SVH
`define LCD_SEGMENT_DELTA_SERIALIZER_MACROS_SVH

// check a condition in the same cycle as its trigger
`define LCDSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcdsd: same-cycle check failed");

// check a condition in the cycle after its trigger
`define LCDSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcdsd: next-cycle check failed");

`endif

>>> rtl/lcdsd_pkg.sv
// Shared types, codes and frame builders for the segment LCD serializer.
// No dependencies.
`default_nettype none

package lcdsd_pkg;

   localparam logic [1:0] MODE_BYTE    = 2'd0;
   localparam logic [1:0] MODE_COMMAND = 2'd1;
   localparam logic [1:0] MODE_NIBBLE  = 2'd2;
   localparam logic [1:0] MODE_UNUSED  = 2'd3;

   localparam logic [2:0] HEAD_COMMAND = 3'b100;
   localparam logic [2:0] HEAD_WRITE   = 3'b101;

   localparam int FRAME_BITS = 13;
   localparam int LEN_W      = 4;
   localparam logic [LEN_W-1:0] LEN_COMMAND = 4'd12;
   localparam logic [LEN_W-1:0] LEN_NIBBLE  = 4'd13;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0] mode;
      logic [3:0] byte_index;
      logic [7:0] value;
      logic [5:0] seg_address;
   } req_type;

   typedef struct packed {
      logic data_bit;
      logic frame_end;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0] first;
      logic [LEN_W-1:0]      first_len;
      logic [FRAME_BITS-1:0] second;
      logic                  has_second;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // head, address MSB first, data LSB first
   function automatic logic [FRAME_BITS-1:0] nibble_frame(input logic [5:0] addr,
                                                          input logic [3:0] data);
      return {HEAD_WRITE, addr, data[0], data[1], data[2], data[3]};
   endfunction

   // head, command MSB first, trailing zero; left aligned with one spare bit
   function automatic logic [FRAME_BITS-1:0] command_frame(input logic [7:0] cmd);
      return {HEAD_COMMAND, cmd, 2'b00};
   endfunction

endpackage

`default_nettype wire

>>> rtl/lcdsd_front.sv
// Front end: accepts items, checks bytes against the shadow copy, builds frames.
// Depends on lcdsd_pkg.
`default_nettype none

module lcdsd_front import lcdsd_pkg::*; #(
   parameter int BUFFER_BYTES = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   input  qstat_type qstat,
   output logic      push_valid,
   output entry_type push_entry
);

   localparam int SHW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

   logic [7:0]     shadow_ff [BUFFER_BYTES];
   logic [4:0]     idx_ext;
   logic [SHW-1:0] sh_idx;
   logic           in_range;
   logic [7:0]     old_byte;
   logic           lo_chg;
   logic           hi_chg;
   logic [5:0]     addr_hi;
   logic [5:0]     addr_lo;
   logic           accept;
   logic           emit;
   logic           shadow_wr;

   assign idx_ext  = {1'b0, req_data.byte_index};
   assign sh_idx   = idx_ext[SHW-1:0];
   assign in_range = {1'b0, idx_ext} < 6'(BUFFER_BYTES);
   assign old_byte = shadow_ff[sh_idx];
   assign lo_chg   = req_data.value[3:0] != old_byte[3:0];
   assign hi_chg   = req_data.value[7:4] != old_byte[7:4];
   assign addr_hi  = {1'b0, req_data.byte_index, 1'b0};
   assign addr_lo  = addr_hi - 6'd1;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;

   always_comb begin
      push_entry = '0;
      emit       = 1'b0;
      unique case (req_data.mode)
         MODE_BYTE: begin
            if (in_range) begin
               if (lo_chg) begin
                  push_entry.first      = nibble_frame(addr_lo, req_data.value[3:0]);
                  push_entry.first_len  = LEN_NIBBLE;
                  push_entry.second     = nibble_frame(addr_hi, req_data.value[7:4]);
                  push_entry.has_second = hi_chg;
                  emit                  = 1'b1;
               end else if (hi_chg) begin
                  push_entry.first     = nibble_frame(addr_hi, req_data.value[7:4]);
                  push_entry.first_len = LEN_NIBBLE;
                  emit                 = 1'b1;
               end
            end
         end
         MODE_COMMAND: begin
            push_entry.first     = command_frame(req_data.value);
            push_entry.first_len = LEN_COMMAND;
            emit                 = 1'b1;
         end
         MODE_NIBBLE: begin
            push_entry.first     = nibble_frame(req_data.seg_address, req_data.value[3:0]);
            push_entry.first_len = LEN_NIBBLE;
            emit                 = 1'b1;
         end
         MODE_UNUSED: begin
            emit = 1'b0;
         end
      endcase
   end

   assign push_valid = accept && emit;
   assign shadow_wr  = accept && (req_data.mode == MODE_BYTE) && in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUFFER_BYTES; i++) begin
            shadow_ff[i] <= 8'h00;
         end
      end else if (shadow_wr) begin
         shadow_ff[sh_idx] <= req_data.value;
      end
   end

endmodule

`default_nettype wire

>>> rtl/lcdsd_queue.sv
// Short frame queue between the front end and the bit serializer.
// Depends on lcdsd_pkg and the assertion macro header.
`default_nettype none
`include "lcd_segment_delta_serializer_macros.svh"

module lcdsd_queue import lcdsd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output qstat_type qstat
);

   entry_type         entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign head        = entries_ff[rd_ptr_ff];
   assign qstat.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign qstat.empty = count_ff == '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `LCDSD_ASSERT_NOW(a_no_push_full, clock, reset, push_valid, !qstat.full)
   `LCDSD_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !qstat.empty)
   `LCDSD_ASSERT_NEXT(a_count_tracks, clock, reset, push_valid && !pop, count_ff != '0)

endmodule

`default_nettype wire

>>> rtl/lcdsd_back.sv
// Back end: shifts queued frames out one bit per transfer through an output register.
// Depends on lcdsd_pkg and the assertion macro header.
`default_nettype none
`include "lcd_segment_delta_serializer_macros.svh"

module lcdsd_back import lcdsd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  entry_type head,
   input  qstat_type qstat,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   logic [FRAME_BITS-1:0] word_ff;
   logic [FRAME_BITS-1:0] word_in;
   logic [FRAME_BITS-1:0] second_ff;
   logic [FRAME_BITS-1:0] second_in;
   logic [LEN_W-1:0]      cnt_ff;
   logic [LEN_W-1:0]      cnt_in;
   logic                  has2_ff;
   logic                  has2_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   logic                  advance;
   logic                  frame_done;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign frame_done = cnt_ff == 4'd1;

   always_comb begin
      word_in      = word_ff;
      second_in    = second_ff;
      cnt_in       = cnt_ff;
      has2_in      = has2_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      priority if (!advance) begin
         rsp_valid_in = rsp_valid_ff;
      end else if (cnt_ff != '0) begin
         rsp_valid_in     = 1'b1;
         rsp_in.data_bit  = word_ff[FRAME_BITS-1];
         rsp_in.frame_end = frame_done;
         rsp_in.last      = frame_done && !has2_ff;
         if (frame_done && has2_ff) begin
            word_in = second_ff;
            cnt_in  = LEN_NIBBLE;
            has2_in = 1'b0;
         end else begin
            word_in = word_ff << 1;
            cnt_in  = cnt_ff - 4'd1;
         end
      end else if (!qstat.empty) begin
         pop              = 1'b1;
         rsp_valid_in     = 1'b1;
         rsp_in.data_bit  = head.first[FRAME_BITS-1];
         rsp_in.frame_end = 1'b0;
         rsp_in.last      = 1'b0;
         word_in          = head.first << 1;
         cnt_in           = head.first_len - 4'd1;
         second_in        = head.second;
         has2_in          = head.has_second;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         has2_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         has2_ff      <= has2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      second_ff <= second_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LCDSD_ASSERT_NOW(a_last_ends_frame, clock, reset, rsp_valid_ff && rsp_ff.last,
                     rsp_ff.frame_end)
   `LCDSD_ASSERT_NOW(a_second_needs_first, clock, reset, has2_ff, cnt_ff != '0)
   `LCDSD_ASSERT_NOW(a_cnt_bounded, clock, reset, 1'b1, cnt_ff <= LEN_NIBBLE)
   `LCDSD_ASSERT_NOW(a_pop_when_idle, clock, reset, pop, cnt_ff == '0)

endmodule

`default_nettype wire

>>> rtl/lcd_segment_delta_serializer.sv
// Top level of the segment LCD serializer: front end, frame queue, bit serializer.
// Depends on lcdsd_pkg, lcdsd_front, lcdsd_queue and lcdsd_back.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_data (mode, byte_index, value, seg_address)
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_data (data_bit, frame_end, last)
//
// One serial bit per cycle from the serializer shift register while rsp_stall is low: a command
// item is 12 bits, a nibble write 13, a byte update 0, 13 or 26.
// An item is taken per cycle while the four-entry frame queue has room.
// Reset clears the shadow copy in the same cycle; no clearing pass follows.
// rsp_stall holds the output register; req_stall rises only when the queue is full.
`default_nettype none

module lcd_segment_delta_serializer import lcdsd_pkg::*; #(
   parameter int BUFFER_BYTES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   qstat_type qstat;
   logic      push_valid;
   entry_type push_entry;
   logic      pop;
   entry_type head;

   lcdsd_front #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .qstat     (qstat),
      .push_valid(push_valid),
      .push_entry(push_entry)
   );

   lcdsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_entry(push_entry),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   lcdsd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .qstat    (qstat),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for lcd_segment_delta_serializer: a directed table, then random
// byte updates, commands and nibble writes under varying idle and stall pressure.
// Depends on lcdsd_pkg and the serializer RTL; serial bits are checked against a predictor.

module testbench import lcdsd_pkg::*;;

   localparam int         HOLD_CYCLES = 300;
   localparam int         PHASE_ITEMS = 48;
   localparam int         HOLD_ITEMS  = 20;
   localparam int         DRAIN_WAIT  = 40;
   localparam int         REPORT_MAX  = 10;
   localparam logic [4:0] PREDICTED   = 5'd31;

   typedef enum logic [2:0] {
      PH_DIRECTED, PH_HOLD, PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH
   } phase_type;

   typedef struct packed {
      req_type     req;
      logic [4:0]  typed_len;
      logic [25:0] typed_bits;
      logic [25:0] typed_ends;
   } stim_row_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   phase_type    traffic_phase = PH_DIRECTED;
   rsp_type      bits_due[$];
   rsp_type      item_bits[$];
   logic [7:0]   shadow_copy [16];
   stim_row_type directed_rows [18];
   int           mismatches = 0;
   int           bit_count  = 0;
   int           hold_count = 0;

   lcd_segment_delta_serializer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic void push_bit(logic b, logic fe);
      item_bits.push_back(rsp_type'{data_bit: b, frame_end: fe, last: 1'b0});
   endfunction

   function automatic void push_write_frame(logic [5:0] addr, logic [3:0] data);
      int k;
      for (k = 2; k >= 0; k--) push_bit(HEAD_WRITE[k], 1'b0);
      for (k = 5; k >= 0; k--) push_bit(addr[k], 1'b0);
      for (k = 0; k < 4; k++) push_bit(data[k], k == 3);
   endfunction

   function automatic void push_command_frame(logic [7:0] cmd);
      int k;
      for (k = 2; k >= 0; k--) push_bit(HEAD_COMMAND[k], 1'b0);
      for (k = 7; k >= 0; k--) push_bit(cmd[k], 1'b0);
      push_bit(1'b0, 1'b1);
   endfunction

   // serial bits of one item; updates the shadow copy
   function automatic void expand_item(req_type r);
      logic [7:0] held;
      logic [5:0] hi_addr;
      item_bits.delete();
      hi_addr = {1'b0, r.byte_index, 1'b0};
      case (r.mode)
         MODE_BYTE: begin
            held = shadow_copy[r.byte_index];
            if (r.value[3:0] != held[3:0]) push_write_frame(hi_addr - 6'd1, r.value[3:0]);
            if (r.value[7:4] != held[7:4]) push_write_frame(hi_addr, r.value[7:4]);
            shadow_copy[r.byte_index] = r.value;
         end
         MODE_COMMAND: push_command_frame(r.value);
         MODE_NIBBLE:  push_write_frame(r.seg_address, r.value[3:0]);
         default: ;
      endcase
   endfunction

   function automatic void commit_item();
      rsp_type t;
      if (item_bits.size() > 0) begin
         t = item_bits.pop_back();
         t.last = 1'b1;
         item_bits.push_back(t);
      end
      while (item_bits.size() > 0) bits_due.push_back(item_bits.pop_front());
   endfunction

   function automatic stim_row_type row(logic [1:0] m, logic [3:0] ix, logic [7:0] v,
                                        logic [5:0] a, logic [4:0] n, logic [25:0] b,
                                        logic [25:0] e);
      stim_row_type s;
      s.req.mode        = m;
      s.req.byte_index  = ix;
      s.req.value       = v;
      s.req.seg_address = a;
      s.typed_len       = n;
      s.typed_bits      = b;
      s.typed_ends      = e;
      return s;
   endfunction

   // half of the items are byte updates, many with no change or one nibble changed
   function automatic req_type pick_item();
      req_type r;
      int k;
      r = req_type'($urandom);
      k = $urandom_range(99);
      if (k < 50) r.mode = MODE_BYTE;
      else if (k < 70) r.mode = MODE_COMMAND;
      else if (k < 92) r.mode = MODE_NIBBLE;
      else r.mode = MODE_UNUSED;
      if (r.mode == MODE_BYTE) begin
         case ($urandom_range(3))
            0: r.value = shadow_copy[r.byte_index];
            1: r.value = shadow_copy[r.byte_index] ^ {4'h0, 4'($urandom_range(15, 1))};
            2: r.value = shadow_copy[r.byte_index] ^ {4'($urandom_range(15, 1)), 4'h0};
            default: ;
         endcase
      end
      return r;
   endfunction

   function automatic int stall_pct(phase_type p);
      case (p)
         PH_RECV_STALL: return 53;
         PH_BOTH:       return 36;
         default:       return 0;
      endcase
   endfunction

   task automatic offer(req_type r, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bits_due.size() > 0) @(posedge clock);
   endtask

   task automatic report(string field, logic want, logic got);
      if (mismatches < REPORT_MAX)
         $display("bit %0d: %s expected %b, got %b", bit_count, field, want, got);
      mismatches++;
   endtask

   // receiver: hold off for a long stretch once, otherwise stall at the phase rate
   always @(posedge clock) begin
      if (traffic_phase == PH_HOLD && hold_count < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         hold_count++;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct(traffic_phase));
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bits_due.size() == 0) begin
            if (mismatches < REPORT_MAX)
               $display("bit %0d: unexpected transfer %b", bit_count, rsp_data);
            mismatches++;
         end else begin
            want = bits_due.pop_front();
            if (rsp_data.data_bit !== want.data_bit)
               report("data_bit", want.data_bit, rsp_data.data_bit);
            if (rsp_data.frame_end !== want.frame_end)
               report("frame_end", want.frame_end, rsp_data.frame_end);
            if (rsp_data.last !== want.last)
               report("last", want.last, rsp_data.last);
         end
         bit_count++;
      end
   end

   initial begin
      req_type   r;
      int        i;
      int        n;
      int        idle;
      phase_type p;

      for (i = 0; i < 16; i++) shadow_copy[i] = 8'h00;

      directed_rows[0]  = row(MODE_COMMAND, 4'd0,  8'h00, 6'd0,  5'd12, 26'h800, 26'h1);
      directed_rows[1]  = row(MODE_COMMAND, 4'd0,  8'hFF, 6'd0,  5'd12, 26'h9FE, 26'h1);
      directed_rows[2]  = row(MODE_NIBBLE,  4'd0,  8'h00, 6'd0,  5'd13, 26'h1400, 26'h1);
      directed_rows[3]  = row(MODE_NIBBLE,  4'd0,  8'h0F, 6'd63, 5'd13, 26'h17FF, 26'h1);
      directed_rows[4]  = row(MODE_NIBBLE,  4'd0,  8'hF6, 6'h2A, PREDICTED, '0, '0);
      directed_rows[5]  = row(MODE_BYTE,    4'd0,  8'h00, 6'd0,  5'd0, '0, '0);
      directed_rows[6]  = row(MODE_BYTE,    4'd0,  8'hFF, 6'd0,  5'd26,
                              {13'h17FF, 13'h140F}, 26'h2001);
      directed_rows[7]  = row(MODE_BYTE,    4'd0,  8'hFF, 6'd0,  5'd0, '0, '0);
      directed_rows[8]  = row(MODE_UNUSED,  4'd15, 8'hFF, 6'd63, 5'd0, '0, '0);
      directed_rows[9]  = row(MODE_BYTE,    4'd15, 8'hFF, 6'd0,  PREDICTED, '0, '0);
      directed_rows[10] = row(MODE_BYTE,    4'd15, 8'hF0, 6'd0,  PREDICTED, '0, '0);
      directed_rows[11] = row(MODE_BYTE,    4'd15, 8'h00, 6'd0,  PREDICTED, '0, '0);
      directed_rows[12] = row(MODE_BYTE,    4'd1,  8'h5A, 6'd21, PREDICTED, '0, '0);
      directed_rows[13] = row(MODE_COMMAND, 4'd15, 8'hA5, 6'd63, PREDICTED, '0, '0);
      directed_rows[14] = row(MODE_BYTE,    4'd8,  8'h80, 6'd0,  PREDICTED, '0, '0);
      directed_rows[15] = row(MODE_NIBBLE,  4'd7,  8'h39, 6'd21, PREDICTED, '0, '0);
      directed_rows[16] = row(MODE_BYTE,    4'd0,  8'h0F, 6'd0,  PREDICTED, '0, '0);
      directed_rows[17] = row(MODE_COMMAND, 4'd0,  8'h5A, 6'd0,  PREDICTED, '0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         offer(directed_rows[i].req, 0);
         expand_item(directed_rows[i].req);
         if (directed_rows[i].typed_len != PREDICTED) begin
            item_bits.delete();
            for (n = directed_rows[i].typed_len - 1; n >= 0; n--)
               push_bit(directed_rows[i].typed_bits[n], directed_rows[i].typed_ends[n]);
         end
         commit_item();
      end
      wait_drained();

      // fill the frame queue against a held receiver
      traffic_phase <= PH_HOLD;
      for (i = 0; i < HOLD_ITEMS; i++) begin
         r = pick_item();
         offer(r, 0);
         expand_item(r);
         commit_item();
      end
      wait_drained();

      for (p = PH_FREE; p != PH_DIRECTED; p = p.next()) begin
         traffic_phase <= p;
         idle = (p == PH_SEND_IDLE) ? 53 : (p == PH_BOTH) ? 36 : 0;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            r = pick_item();
            offer(r, idle);
            expand_item(r);
            commit_item();
         end
         wait_drained();
         if (p == PH_BOTH) break;
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && bits_due.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/lcdsd_pkg.sv
rtl/lcdsd_front.sv
rtl/lcdsd_queue.sv
rtl/lcdsd_back.sv
rtl/lcd_segment_delta_serializer.sv
sim/testbench.sv
